// ----- hw/rtl/mnnr_pkg.sv -----
// Package for the mask resizer: sizes, codes, payload types and the divider step.
package mnnr_pkg;

    // Sizes of the source store and the target raster.
    localparam int MAX_SIDE        = 256;
    localparam int MAX_TARGET_SIDE = 4096;
    localparam int STORE_DEPTH     = MAX_SIDE * MAX_SIDE;
    localparam int ADDR_W          = $clog2(STORE_DEPTH);
    localparam int COUNT_W         = 17;
    localparam int SIDE_W          = 9;
    localparam int TARGET_W        = 13;
    localparam int POS_W           = 12;
    localparam int PIXEL_W         = 8;

    // The divider takes four quotient bits per cycle over a 20-bit dividend.
    localparam int PROD_W    = 20;
    localparam int DIV_BITS  = 4;
    localparam int DIV_STEPS = PROD_W / DIV_BITS;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    // Operation codes of an input request.
    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_LOAD  = 2'd1;
    localparam logic [1:0] OP_EMIT  = 2'd2;

    // Configuration register indexes.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 13;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DST_HEIGHT = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic [PIXEL_W-1:0] pixel_in;
    } in_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] mask_value;
        logic               last;
    } out_t;

    // Partial remainder and dividend/quotient word of the restoring divider.
    typedef struct packed {
        logic [TARGET_W-1:0] rem;
        logic [PROD_W-1:0]   dvd;
    } div_state_t;

    // Four restoring division steps; quotient bits shift in at the bottom.
    function automatic div_state_t div_step(input div_state_t cur,
                                            input logic [TARGET_W-1:0] divisor);
        div_state_t          st;
        logic [TARGET_W:0]   trial;
        st = cur;
        for (int i = 0; i < DIV_BITS; i++) begin
            trial  = {st.rem, st.dvd[PROD_W-1]};
            st.dvd = {st.dvd[PROD_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor}) begin
                trial     = trial - {1'b0, divisor};
                st.dvd[0] = 1'b1;
            end
            st.rem = trial[TARGET_W-1:0];
        end
        return st;
    endfunction

endpackage

// ----- hw/rtl/mask_nearest_neighbor_resize.sv -----
// Nearest-neighbour resizer of a byte mask, with its source store and divider.
//
//  channel  ports                          direction  carries
//  s_       s_valid s_ready s_data         in         operation, pixel_in
//  m_       m_valid m_ready m_data         out        mask_value, last
//  cfg_     cfg_valid cfg_ready cfg_index  in         register index and data
//           cfg_data
//
// Start and load requests are taken in the idle state; a load writes one store entry
// until the store is full. An emit that produces a pixel runs from acceptance to the output
// register through the row and column dividers (run in parallel, four quotient bits a cycle),
// the store address multiply, the store read and the hand-over.
// Reset is synchronous; the store is not cleared and needs no clearing pass.
// A stalled output register holds its pixel while further loads are accepted;
// the next emit waits in its last stage until that pixel has been taken.
module mask_nearest_neighbor_resize
    import mnnr_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_t                    s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_t                   m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_ADDR = 3'd2;
    localparam logic [2:0] ST_READ = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]          state_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [SIDE_W-1:0]   src_width_reg;
    logic [SIDE_W-1:0]   src_height_reg;
    logic [TARGET_W-1:0] dst_width_reg;
    logic [TARGET_W-1:0] dst_height_reg;
    logic [COUNT_W-1:0]  loaded_count_reg;
    logic [POS_W-1:0]    out_col_reg;
    logic [POS_W-1:0]    out_row_reg;
    logic                frame_done_reg;
    div_state_t          div_y_reg;
    div_state_t          div_x_reg;
    logic [TARGET_W-1:0] dw_reg;
    logic [TARGET_W-1:0] dh_reg;
    logic                src_ok_reg;
    logic                last_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [PIXEL_W-1:0]  rdata_reg;
    logic                m_valid_reg;
    out_t                m_data_reg;

    logic [PIXEL_W-1:0]  mask_store [STORE_DEPTH];

    logic                s_fire;
    logic                cfg_fire;
    logic [TARGET_W-1:0] dw;
    logic [TARGET_W-1:0] dh;
    logic                emit_go;
    logic                src_ok;
    logic [2*SIDE_W-1:0] src_area;
    logic [PROD_W-1:0]   prod_y;
    logic [PROD_W-1:0]   prod_x;
    logic                is_last;
    logic                col_wrap;
    logic                load_we;
    logic [SIDE_W-1:0]   lim_y;
    logic [SIDE_W-1:0]   lim_x;
    logic [SIDE_W-1:0]   sy;
    logic [SIDE_W-1:0]   sx;
    logic [COUNT_W-1:0]  idx;
    logic                out_free;

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign out_free  = !m_valid_reg || m_ready;

    // Target sizes above the raster limit count as the limit.
    assign dw = (dst_width_reg > TARGET_W'(MAX_TARGET_SIDE)) ?
                TARGET_W'(MAX_TARGET_SIDE) : dst_width_reg;
    assign dh = (dst_height_reg > TARGET_W'(MAX_TARGET_SIDE)) ?
                TARGET_W'(MAX_TARGET_SIDE) : dst_height_reg;

    // Source check: non-empty, within the store, and fully loaded.
    assign src_area = (2*SIDE_W)'(src_width_reg) * (2*SIDE_W)'(src_height_reg);
    assign src_ok   = (src_width_reg != '0) && (src_height_reg != '0) &&
                      (src_width_reg <= SIDE_W'(MAX_SIDE)) &&
                      (src_height_reg <= SIDE_W'(MAX_SIDE)) &&
                      ((2*SIDE_W)'(loaded_count_reg) == src_area);

    // Scaled raster positions form the dividends.
    assign prod_y = PROD_W'(out_row_reg) * PROD_W'(src_height_reg);
    assign prod_x = PROD_W'(out_col_reg) * PROD_W'(src_width_reg);

    // Raster bookkeeping for the pixel being emitted.
    assign emit_go  = s_fire && (s_data.operation == OP_EMIT) &&
                      (dw != '0) && (dh != '0) && !frame_done_reg;
    assign is_last  = ({1'b0, out_row_reg} == dh - TARGET_W'(1)) &&
                      ({1'b0, out_col_reg} == dw - TARGET_W'(1));
    assign col_wrap = ({1'b0, out_col_reg} + TARGET_W'(1)) >= dw;
    assign load_we  = s_fire && (s_data.operation == OP_LOAD) &&
                      !loaded_count_reg[COUNT_W-1];

    // Quotients are limited to the last source row and column.
    assign lim_y = src_height_reg - SIDE_W'(1);
    assign lim_x = src_width_reg - SIDE_W'(1);
    assign sy    = (div_y_reg.dvd > PROD_W'(lim_y)) ? lim_y : div_y_reg.dvd[SIDE_W-1:0];
    assign sx    = (div_x_reg.dvd > PROD_W'(lim_x)) ? lim_x : div_x_reg.dvd[SIDE_W-1:0];
    assign idx   = COUNT_W'(sy[PIXEL_W-1:0]) * COUNT_W'(src_width_reg) +
                   COUNT_W'(sx[PIXEL_W-1:0]);

    // Source store: one write port for loads, one registered read port.
    always_ff @(posedge aclk) begin
        if (load_we) begin
            mask_store[loaded_count_reg[ADDR_W-1:0]] <= s_data.pixel_in;
        end
        rdata_reg <= mask_store[addr_reg];
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_width_reg  <= '0;
            src_height_reg <= '0;
            dst_width_reg  <= '0;
            dst_height_reg <= '0;
        end else if (cfg_fire) begin
            case (cfg_index)
                REG_SRC_WIDTH:  src_width_reg  <= cfg_data[SIDE_W-1:0];
                REG_SRC_HEIGHT: src_height_reg <= cfg_data[SIDE_W-1:0];
                REG_DST_WIDTH:  dst_width_reg  <= cfg_data;
                REG_DST_HEIGHT: dst_height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Frame counters and the request sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            loaded_count_reg <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            frame_done_reg   <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            // The hand-over stage refills the output itself when it is taken.
            if (m_valid_reg && m_ready && state_reg != ST_OUT) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_fire) begin
                        case (s_data.operation)
                            OP_START: begin
                                loaded_count_reg <= '0;
                                out_col_reg      <= '0;
                                out_row_reg      <= '0;
                                frame_done_reg   <= 1'b0;
                            end
                            OP_LOAD: begin
                                if (loaded_count_reg != COUNT_MAX) begin
                                    loaded_count_reg <= loaded_count_reg + COUNT_W'(1);
                                end
                            end
                            default: ;
                        endcase
                        if (emit_go) begin
                            state_reg <= ST_DIV;
                            step_reg  <= '0;
                            if (is_last) begin
                                frame_done_reg <= 1'b1;
                                out_col_reg    <= '0;
                                out_row_reg    <= '0;
                            end else if (col_wrap) begin
                                out_col_reg <= '0;
                                out_row_reg <= out_row_reg + POS_W'(1);
                            end else begin
                                out_col_reg <= out_col_reg + POS_W'(1);
                            end
                        end
                    end
                end
                ST_DIV: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                        state_reg <= ST_ADDR;
                    end
                end
                ST_ADDR: begin
                    state_reg <= ST_READ;
                end
                ST_READ: begin
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers of the emit pipeline.
    always_ff @(posedge aclk) begin
        if (emit_go) begin
            div_y_reg  <= '{rem: '0, dvd: prod_y};
            div_x_reg  <= '{rem: '0, dvd: prod_x};
            dh_reg     <= dh;
            dw_reg     <= dw;
            src_ok_reg <= src_ok;
            last_reg   <= is_last;
        end else if (state_reg == ST_DIV) begin
            div_y_reg <= div_step(div_y_reg, dh_reg);
            div_x_reg <= div_step(div_x_reg, dw_reg);
        end
        if (state_reg == ST_ADDR) begin
            addr_reg <= idx[ADDR_W-1:0];
        end
        if (state_reg == ST_OUT && out_free) begin
            m_data_reg.mask_value <= src_ok_reg ? rdata_reg : PIXEL_W'(1);
            m_data_reg.last       <= last_reg;
        end
    end

`ifndef SYNTH
    // A load below saturation advances the count by exactly one.
    a_load_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_data.operation == OP_LOAD && loaded_count_reg != COUNT_MAX)
        |=> loaded_count_reg == $past(loaded_count_reg) + COUNT_W'(1))
        else $error("load count did not advance");

    // The divider leaves after its last step.
    a_div_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && step_reg == STEP_W'(DIV_STEPS - 1))
        |=> state_reg == ST_ADDR)
        else $error("divider did not finish on time");

    // A new result only comes from the hand-over stage.
    a_out_origin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result raised outside the hand-over stage");

    // A valid frame only reads entries that were loaded.
    a_addr_loaded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_READ && src_ok_reg)
        |-> COUNT_W'(addr_reg) < loaded_count_reg)
        else $error("store read beyond the loaded pixels");
`endif

endmodule
